/* hdl/rvx_pkg.sv */
// shared types, codes and constants for the rv32i instruction executor
// no dependencies
`default_nettype none

package rvx_pkg;

	localparam int unsigned MemoryBytesDefault = 65536;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned CfgIndexWidth = 8;

	// opcodes
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// alu funct3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch funct3
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// load / store funct3
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;
	localparam logic [2:0] F3_SB  = 3'd0;
	localparam logic [2:0] F3_SH  = 3'd1;
	localparam logic [2:0] F3_SW  = 3'd2;

	localparam logic [2:0]  F3_PRIV    = 3'd0;
	localparam logic [11:0] F12_ECALL  = 12'd0;
	localparam logic [11:0] F12_EBREAK = 12'd1;
	localparam logic [6:0]  F7_BASE    = 7'h00;
	localparam logic [6:0]  F7_ALT     = 7'h20;

	localparam logic [31:0] NOP_WORD   = 32'h0000_0013;
	localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;
	localparam logic [31:0] EXIT_CODE  = 32'd93;
	localparam logic [4:0]  REG_A0     = 5'd10;
	localparam logic [4:0]  REG_A7     = 5'd17;

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] CFG_START_ADDRESS = 8'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_MEMORY_LIMIT  = 8'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_UART_DATA     = 8'd2;
	localparam logic [CfgIndexWidth-1:0] CFG_UART_STATUS   = 8'd3;

	localparam logic [31:0] RESET_START_ADDRESS = 32'h0000_0000;
	localparam logic [16:0] RESET_MEMORY_LIMIT  = 17'h1_0000;
	localparam logic [31:0] RESET_UART_DATA     = 32'h1000_0000;
	localparam logic [31:0] RESET_UART_STATUS   = 32'h1000_0005;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_HALT  = 2'd1,
		STAT_ERROR = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		C_NOP,
		C_LUI,
		C_AUIPC,
		C_JAL,
		C_JALR,
		C_BRANCH,
		C_LOAD,
		C_STORE,
		C_OPIMM,
		C_OP,
		C_ECALL,
		C_EBREAK,
		C_ERR
	} iclass_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_FETCH,
		ST_EXEC,
		ST_LOAD
	} bstate_t;

	typedef struct packed {
		logic [31:0] word;
		iclass_t     cls;
	} fq_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] next_address;
		logic        console_valid;
		logic [7:0]  console_byte;
		logic [31:0] exit_argument;
	} result_t;

	typedef struct packed {
		logic                     valid;
		logic [CfgIndexWidth-1:0] index;
		logic [31:0]              data;
	} cfg_wr_t;

endpackage

`default_nettype wire

/* hdl/rvx_fifo.sv */
// small first-in first-out queue of flip-flops
// depends on nothing
`default_nettype none

module rvx_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

/* hdl/rvx_front.sv */
// front end: accepts instruction words, classifies them and queues them
// depends on rvx_pkg and rvx_fifo
`default_nettype none

module rvx_front
	import rvx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [31:0] instruction_word,
	output logic             full,
	input  wire logic        hold,
	input  wire logic        iq_pop,
	output fq_item_t         iq_item,
	output logic             iq_empty
);

	logic     q_full;
	fq_item_t item;
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [11:0] f12;

	always_comb begin
		opc = instruction_word[6:0];
		f3  = instruction_word[14:12];
		f7  = instruction_word[31:25];
		f12 = instruction_word[31:20];
		item.word = instruction_word;
		item.cls  = C_ERR;
		if (instruction_word == NOP_WORD || instruction_word == '0) begin
			item.cls = C_NOP;
		end else begin
			case (opc)
				OPC_LUI:    item.cls = C_LUI;
				OPC_AUIPC:  item.cls = C_AUIPC;
				OPC_JAL:    item.cls = C_JAL;
				OPC_JALR:   item.cls = C_JALR;
				OPC_BRANCH: item.cls = (f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU,
					F3_BGEU}) ? C_BRANCH : C_ERR;
				OPC_LOAD:   item.cls = (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) ?
					C_LOAD : C_ERR;
				OPC_STORE:  item.cls = (f3 inside {F3_SB, F3_SH, F3_SW}) ? C_STORE : C_ERR;
				OPC_OPIMM:  item.cls = (f3 == F3_SR && !(f7 inside {F7_BASE, F7_ALT})) ?
					C_ERR : C_OPIMM;
				OPC_OP:     item.cls = ((f3 == F3_ADD || f3 == F3_SR) &&
					!(f7 inside {F7_BASE, F7_ALT})) ? C_ERR : C_OP;
				OPC_SYSTEM: begin
					if (f3 == F3_PRIV && f12 == F12_ECALL) begin
						item.cls = C_ECALL;
					end else if (f3 == F3_PRIV && f12 == F12_EBREAK) begin
						item.cls = C_EBREAK;
					end else begin
						item.cls = C_NOP;
					end
				end
				default:    item.cls = C_ERR;
			endcase
		end
	end

	// no requests are taken while the memory clearing pass runs
	assign full = q_full || hold;

	rvx_fifo #(
		.W     ($bits(fq_item_t)),
		.DEPTH (QueueDepth)
	) u_iq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !hold),
		.din    (item),
		.full   (q_full),
		.pop    (iq_pop),
		.dout   (iq_item),
		.empty  (iq_empty)
	);

endmodule

`default_nettype wire

/* hdl/rvx_regfile.sv */
// 32 x 32 register file with two registered read ports and valid bits for reset
// depends on nothing
`default_nettype none

module rvx_regfile (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        re,
	input  wire logic [4:0]  ra1,
	input  wire logic [4:0]  ra2,
	output logic [31:0]      rd1,
	output logic [31:0]      rd2,
	input  wire logic        we,
	input  wire logic [4:0]  wa,
	input  wire logic [31:0] wd
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] d1_q, d2_q;
	logic        v1_q, v2_q;

	// x0 is never written, so its valid bit stays low and it reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			if (we && wa != '0) begin
				valid_q[wa] <= 1'b1;
			end
			if (re) begin
				v1_q <= valid_q[ra1];
				v2_q <= valid_q[ra2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && wa != '0) begin
			mem[wa] <= wd;
		end
		if (re) begin
			d1_q <= mem[ra1];
			d2_q <= mem[ra2];
		end
	end

	assign rd1 = v1_q ? d1_q : '0;
	assign rd2 = v2_q ? d2_q : '0;

endmodule

`default_nettype wire

/* hdl/rvx_back.sv */
// back end: sequencer, alu, branch unit, data memory and architectural state
// depends on rvx_pkg and rvx_regfile
`default_nettype none

module rvx_back
	import rvx_pkg::*;
#(
	parameter int unsigned MEMORY_BYTES = MemoryBytesDefault
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_wr_t  cfg,
	input  wire logic     iq_empty,
	input  wire fq_item_t iq_item,
	output logic          iq_pop,
	output logic          clearing,
	input  wire logic     res_full,
	output logic          res_push,
	output result_t       res
);

	localparam int unsigned Rows = MEMORY_BYTES / 4;
	localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;

	bstate_t     state_q, state_d;
	fq_item_t    inst_s1;
	logic [31:0] pc_q;
	logic [16:0] mem_limit_q;
	logic [31:0] uart_data_q, uart_stat_q;
	logic [RowW-1:0] clr_q;
	logic [1:0]  ld_off_q;

	logic [31:0] dmem [Rows];
	logic [31:0] mrd_q;

	logic        rf_re, rf_we;
	logic [4:0]  ra1, ra2;
	logic [31:0] a, b, rf_wd;

	logic        m_we, m_re;
	logic [3:0]  m_be;
	logic [RowW-1:0] m_wrow, m_rrow;
	logic [31:0] m_wd;

	logic [31:0] w, immi, imms, immb, immj, immu, op2, addr, alu, pc4, nxt, ldv, lsh;
	logic [2:0]  f3;
	logic [4:0]  rd, sh;
	logic        take, wr, bad_mem, uart_d, uart_s, load_go, pc_we;
	logic [32:0] end33, lim33;
	logic [2:0]  size;
	status_t     st;

	rvx_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (rf_re),
		.ra1    (ra1),
		.ra2    (ra2),
		.rd1    (a),
		.rd2    (b),
		.we     (rf_we),
		.wa     (rd),
		.wd     (rf_wd)
	);

	// decode and execute of the held instruction
	always_comb begin
		w    = inst_s1.word;
		f3   = w[14:12];
		rd   = w[11:7];
		immi = {{20{w[31]}}, w[31:20]};
		imms = {{20{w[31]}}, w[31:25], w[11:7]};
		immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		immu = w & UPPER_MASK;
		pc4  = pc_q + 32'd4;
		addr = a + ((inst_s1.cls == C_STORE) ? imms : immi);
		op2  = (inst_s1.cls == C_OP) ? b : immi;
		sh   = op2[4:0];

		case (f3)
			F3_ADD:  alu = (inst_s1.cls == C_OP && w[30]) ? a - op2 : a + op2;
			F3_SLL:  alu = a << sh;
			F3_SLT:  alu = {31'd0, $signed(a) < $signed(op2)};
			F3_SLTU: alu = {31'd0, a < op2};
			F3_XOR:  alu = a ^ op2;
			F3_SR:   alu = w[30] ? 32'($signed(a) >>> sh) : a >> sh;
			F3_OR:   alu = a | op2;
			default: alu = a & op2;
		endcase

		case (f3)
			F3_BEQ:  take = (a == b);
			F3_BNE:  take = (a != b);
			F3_BLT:  take = ($signed(a) < $signed(b));
			F3_BGE:  take = ($signed(a) >= $signed(b));
			F3_BLTU: take = (a < b);
			F3_BGEU: take = (a >= b);
			default: take = 1'b0;
		endcase

		case (f3[1:0])
			2'd0:    size = 3'd1;
			2'd1:    size = 3'd2;
			default: size = 3'd4;
		endcase
		end33 = {1'b0, addr} + 33'(size);
		lim33 = (33'(mem_limit_q) < 33'(MEMORY_BYTES)) ? 33'(mem_limit_q) : 33'(MEMORY_BYTES);
		bad_mem = (end33 > lim33) || (size == 3'd2 && addr[0]) ||
			(size == 3'd4 && addr[1:0] != 2'd0);
		uart_d = (addr == uart_data_q);
		uart_s = (addr == uart_stat_q);

		st  = STAT_DONE;
		wr  = 1'b0;
		nxt = pc4;
		res.console_valid = 1'b0;
		res.console_byte  = '0;
		res.exit_argument = '0;
		case (inst_s1.cls)
			C_LUI:    begin wr = 1'b1; end
			C_AUIPC:  begin wr = 1'b1; end
			C_JAL:    begin wr = 1'b1; nxt = pc_q + immj; end
			C_JALR:   begin wr = 1'b1; nxt = addr & ~32'd1; end
			C_BRANCH: begin
				if (take) begin
					nxt = pc_q + immb;
				end
			end
			C_LOAD:   begin
				if (bad_mem) begin
					st = STAT_ERROR;
				end
			end
			C_STORE:  begin
				if (uart_d) begin
					res.console_valid = 1'b1;
					res.console_byte  = b[7:0];
				end else if (!uart_s && bad_mem) begin
					st = STAT_ERROR;
				end
			end
			C_OPIMM, C_OP: begin wr = 1'b1; end
			C_ECALL:  begin
				// a7 is on read port one, a0 on read port two
				if (a == EXIT_CODE || a == '0) begin
					st = STAT_HALT;
					res.exit_argument = b;
				end
			end
			C_EBREAK: begin st = STAT_HALT; end
			C_ERR:    begin st = STAT_ERROR; end
			default:  begin end
		endcase
		if (st != STAT_DONE) begin
			nxt = pc_q;
		end
		res.status       = st;
		res.next_address = nxt;
	end

	// load data alignment and extension
	always_comb begin
		lsh = mrd_q >> {ld_off_q, 3'b000};
		case (f3)
			F3_LB:   ldv = {{24{lsh[7]}}, lsh[7:0]};
			F3_LH:   ldv = {{16{lsh[15]}}, lsh[15:0]};
			F3_LBU:  ldv = {24'd0, lsh[7:0]};
			F3_LHU:  ldv = {16'd0, lsh[15:0]};
			default: ldv = lsh;
		endcase
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		iq_pop   = 1'b0;
		rf_re    = 1'b0;
		rf_we    = 1'b0;
		rf_wd    = alu;
		res_push = 1'b0;
		m_we     = 1'b0;
		m_re     = 1'b0;
		m_be     = 4'b1111;
		m_wrow   = addr[RowW+1:2];
		m_rrow   = addr[RowW+1:2];
		m_wd     = b << {addr[1:0], 3'b000};
		pc_we    = 1'b0;
		load_go  = 1'b0;
		ra1      = (iq_item.cls == C_ECALL) ? REG_A7 : iq_item.word[19:15];
		ra2      = (iq_item.cls == C_ECALL) ? REG_A0 : iq_item.word[24:20];
		case (inst_s1.cls)
			C_LUI:           rf_wd = immu;
			C_AUIPC:         rf_wd = pc_q + immu;
			C_JAL, C_JALR:   rf_wd = pc4;
			default:         rf_wd = alu;
		endcase
		case (state_q)
			ST_CLEAR: begin
				m_we   = 1'b1;
				m_wrow = clr_q;
				m_wd   = '0;
				if (clr_q == RowW'(Rows - 1)) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (!iq_empty) begin
					iq_pop  = 1'b1;
					rf_re   = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!res_full) begin
					if (inst_s1.cls == C_LOAD && st == STAT_DONE) begin
						m_re    = 1'b1;
						load_go = 1'b1;
						state_d = ST_LOAD;
					end else begin
						res_push = 1'b1;
						pc_we    = (st == STAT_DONE);
						rf_we    = (st == STAT_DONE) && wr;
						if (inst_s1.cls == C_STORE && st == STAT_DONE && !uart_d && !uart_s) begin
							m_we = 1'b1;
							case (f3)
								F3_SB:   m_be = 4'b0001 << addr[1:0];
								F3_SH:   m_be = 4'b0011 << addr[1:0];
								default: m_be = 4'b1111;
							endcase
						end
						state_d = ST_FETCH;
					end
				end
			end
			ST_LOAD: begin
				res_push = 1'b1;
				pc_we    = 1'b1;
				rf_we    = 1'b1;
				rf_wd    = ldv;
				state_d  = ST_FETCH;
			end
			default: state_d = ST_FETCH;
		endcase
	end

	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pc_q        <= RESET_START_ADDRESS;
			mem_limit_q <= RESET_MEMORY_LIMIT;
			uart_data_q <= RESET_UART_DATA;
			uart_stat_q <= RESET_UART_STATUS;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pc_we) begin
				pc_q <= (state_q == ST_LOAD) ? pc4 : nxt;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_START_ADDRESS: pc_q        <= cfg.data;
					CFG_MEMORY_LIMIT:  mem_limit_q <= cfg.data[16:0];
					CFG_UART_DATA:     uart_data_q <= cfg.data;
					CFG_UART_STATUS:   uart_stat_q <= cfg.data;
					default: begin end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (iq_pop) begin
			inst_s1 <= iq_item;
		end
		if (load_go) begin
			ld_off_q <= addr[1:0];
		end
	end

	// data memory, one word row with byte enables
	always_ff @(posedge clk) begin
		if (m_we) begin
			for (int i = 0; i < 4; i++) begin
				if (m_be[i]) begin
					dmem[m_wrow][8*i +: 8] <= m_wd[8*i +: 8];
				end
			end
		end
		if (m_re) begin
			mrd_q <= dmem[m_rrow];
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_load_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ($past(state_q) == ST_EXEC))
		else $error("load completion without execute");

	a_error_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.status != STAT_DONE) |=> (pc_q == $past(pc_q)) ||
		$past(cfg.valid))
		else $error("program counter moved on error or halt");

	a_no_issue_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !iq_pop && !res_push)
		else $error("instruction issued during memory clear");

endmodule

`default_nettype wire

/* hdl/rv32i_instruction_executor.sv */
// Executes one RV32I instruction per request against its own register file, program counter
// and data memory. After reset a clearing pass zeroes the data memory, during which full
// stays high; configuration writes are taken at any time. Each instruction then passes
// through the execute sequencer as a register file read, then execute and write back;
// loads add a further step because the data memory read is registered. A two-entry
// request queue and a two-entry result queue let both sides stall on their own.
// depends on rvx_pkg, rvx_front, rvx_back, rvx_fifo
`default_nettype none

module rv32i_instruction_executor
	import rvx_pkg::*;
#(
	parameter int unsigned MEMORY_BYTES = MemoryBytesDefault
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [31:0]              instruction_word,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [1:0]                    status,
	output logic [31:0]                   next_address,
	output logic                          console_valid,
	output logic [7:0]                    console_byte,
	output logic [31:0]                   exit_argument,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [31:0]              cfg_data
);

	fq_item_t iq_item;
	logic     iq_empty, iq_pop, clearing, res_full, res_push;
	result_t  res_in, res_out;
	cfg_wr_t  cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	rvx_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.instruction_word (instruction_word),
		.full             (full),
		.hold             (clearing),
		.iq_pop           (iq_pop),
		.iq_item          (iq_item),
		.iq_empty         (iq_empty)
	);

	rvx_back #(
		.MEMORY_BYTES (MEMORY_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.iq_empty (iq_empty),
		.iq_item  (iq_item),
		.iq_pop   (iq_pop),
		.clearing (clearing),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	rvx_fifo #(
		.W     ($bits(result_t)),
		.DEPTH (QueueDepth)
	) u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign status        = res_out.status;
	assign next_address  = res_out.next_address;
	assign console_valid = res_out.console_valid;
	assign console_byte  = res_out.console_byte;
	assign exit_argument = res_out.exit_argument;

endmodule

`default_nettype wire
